### design/mbe_pkg.sv
// Shared widths, register indexes and reset values for the escape-time pixel engine.
package mbe_pkg;

  // Signed width of the pixel-times-span product and of the mapped quotient.
  localparam int PROD_W    = 46;
  // Width of the clamped grid size used as divisor.
  localparam int DIV_W     = 13;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [2:0] REG_X_MIN      = 3'd0;
  localparam logic [2:0] REG_X_MAX      = 3'd1;
  localparam logic [2:0] REG_Y_MIN      = 3'd2;
  localparam logic [2:0] REG_Y_MAX      = 3'd3;
  localparam logic [2:0] REG_GRID_SIZE  = 3'd4;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd5;

  localparam logic signed [31:0] X_MIN_RST = -32'sd536870912;
  localparam logic signed [31:0] X_MAX_RST = 32'sd126164644;
  localparam logic signed [31:0] Y_MIN_RST = -32'sd300647711;
  localparam logic signed [31:0] Y_MAX_RST = 32'sd300647711;
  localparam logic [12:0]        GRID_RST  = 13'd480;
  localparam logic [15:0]        LIMIT_RST = 16'd1000;

endpackage

### design/mbe_div.sv
// Bit-serial restoring divider: signed dividend by unsigned divisor, truncating toward zero.
module mbe_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [mbe_pkg::PROD_W-1:0]  dividend,
  input  logic        [mbe_pkg::DIV_W-1:0]   divisor,
  output logic                               done,
  output logic signed [mbe_pkg::PROD_W-1:0]  quotient
);
  import mbe_pkg::*;

  logic                 active;
  logic                 neg;
  logic [PROD_W-1:0]    mag;   // dividend bits shift out, quotient bits shift in
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvsr;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DIV_W:0]       trial;
  logic                 fits;

  assign trial = {rem, mag[PROD_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == DIV_CNT_W'(1));
      if (start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(PROD_W);
      end else if (active) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[PROD_W-1];
      mag  <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
      rem  <= '0;
      dvsr <= divisor;
    end else if (active) begin
      rem <= fits ? DIV_W'(trial - {1'b0, dvsr}) : trial[DIV_W-1:0];
      mag <= {mag[PROD_W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

`ifndef SYNTHESIS
  a_start_runs: assert property (@(posedge clk) disable iff (rst) start |=> active)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !active)
    else $error("divider done while still running");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) active |-> cnt != '0)
    else $error("divider running with empty count");
`endif

endmodule

### design/mandelbrot_escape_time_pixel.sv
// Top level of the escape-time pixel engine: window mapping and z = z*z + c loop.
// The pixel is mapped axis by axis (multiply, divider start, 46 serial divide steps
//   by the grid size, quotient pickup); each iteration then runs x*x, y*y, x*y, update.
// done rises when the point escapes or when the iteration limit is reached; for a
//   limit of zero it rises at the end of the mapping, with no iteration run.
// Throughput: one pixel at a time, next start in the done cycle; the result shows once.
// rst (synchronous, active high) returns to idle and loads the default window.
module mandelbrot_escape_time_pixel #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [11:0] column,
  input  logic [11:0] row,
  // result side
  output logic        done,
  output logic [15:0] escape_count,
  output logic        inside_set,
  // configuration writes
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);
  import mbe_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MX      = 4'd1;  // col * x span
  localparam logic [3:0] S_DX_GO   = 4'd2;
  localparam logic [3:0] S_DX_WAIT = 4'd3;
  localparam logic [3:0] S_MY      = 4'd4;  // row * y span
  localparam logic [3:0] S_DY_GO   = 4'd5;
  localparam logic [3:0] S_DY_WAIT = 4'd6;
  localparam logic [3:0] S_SQX     = 4'd7;  // x*x
  localparam logic [3:0] S_SQY     = 4'd8;  // y*y
  localparam logic [3:0] S_XY      = 4'd9;  // escape test, x*y
  localparam logic [3:0] S_UPD     = 4'd10; // z update

  // 4.0 in the fixed-point format, held wide enough for xx + yy
  localparam logic signed [66:0] FOUR = 67'sd4 <<< FRAC_BITS;

  // Configuration registers
  logic signed [31:0] x_min, x_max, y_min, y_max;
  logic [12:0]        grid_size;
  logic [15:0]        iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min           <= X_MIN_RST;
      x_max           <= X_MAX_RST;
      y_min           <= Y_MIN_RST;
      y_max           <= Y_MAX_RST;
      grid_size       <= GRID_RST;
      iteration_limit <= LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_X_MIN:      x_min           <= wr_data;
        REG_X_MAX:      x_max           <= wr_data;
        REG_Y_MIN:      y_min           <= wr_data;
        REG_Y_MAX:      y_max           <= wr_data;
        REG_GRID_SIZE:  grid_size       <= wr_data[12:0];
        REG_ITER_LIMIT: iteration_limit <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [3:0]         state;
  logic [11:0]        col_q, row_q;
  logic signed [31:0] x0, y0, x, y;
  logic [15:0]        iter;
  logic signed [65:0] mul_q;       // registered output of the shared multiplier
  logic signed [65:0] xx_q, yy_q;

  // Grid size of zero reads as one; above MAX_DIM it is clamped.
  logic [DIV_W-1:0] n_eff;
  always_comb begin
    if (grid_size == '0) begin
      n_eff = DIV_W'(1);
    end else if (32'(grid_size) > MAX_DIM) begin
      n_eff = DIV_W'(MAX_DIM);
    end else begin
      n_eff = grid_size;
    end
  end

  logic signed [32:0] span_x, span_y;
  assign span_x = 33'(x_max) - 33'(x_min);
  assign span_y = 33'(y_max) - 33'(y_min);

  // Shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    case (state)
      S_MX: begin
        mul_a = {21'b0, col_q};
        mul_b = span_x;
      end
      S_MY: begin
        mul_a = {21'b0, row_q};
        mul_b = span_y;
      end
      S_SQX: begin
        mul_a = 33'(x);
        mul_b = 33'(x);
      end
      S_SQY: begin
        mul_a = 33'(y);
        mul_b = 33'(y);
      end
      default: begin
        mul_a = 33'(x);
        mul_b = 33'(y);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // Window mapping divider
  logic                     div_start, div_done;
  logic signed [PROD_W-1:0] div_q;
  assign div_start = (state == S_DX_GO) || (state == S_DY_GO);

  mbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(mul_q[PROD_W-1:0])),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Iteration datapath; products are floored by the arithmetic shift
  logic signed [65:0] prod_sh;
  logic signed [66:0] mag2;
  logic signed [31:0] mapped_x, mapped_y, x_new, y_new;
  logic [15:0]        iter_inc;

  assign prod_sh  = mul_q >>> FRAC_BITS;
  assign mag2     = 67'(xx_q) + 67'(prod_sh);
  assign mapped_x = sat32(66'(x_min) + 66'(div_q));
  assign mapped_y = sat32(66'(y_min) + 66'(div_q));
  assign x_new    = sat32(xx_q - yy_q + 66'(x0));
  assign y_new    = sat32((prod_sh <<< 1) + 66'(y0));
  assign iter_inc = iter + 16'd1;

  // Sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE:    if (start) state <= S_MX;
        S_MX:      state <= S_DX_GO;
        S_DX_GO:   state <= S_DX_WAIT;
        S_DX_WAIT: if (div_done) state <= S_MY;
        S_MY:      state <= S_DY_GO;
        S_DY_GO:   state <= S_DY_WAIT;
        S_DY_WAIT: begin
          if (div_done) begin
            if (iteration_limit == '0) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX:     state <= S_SQY;
        S_SQY:     state <= S_XY;
        S_XY: begin
          if (mag2 >= FOUR) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (iter_inc >= iteration_limit) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_SQX;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col_q <= column;
        row_q <= row;
      end
      S_DX_WAIT: if (div_done) x0 <= mapped_x;
      S_DY_WAIT: begin
        if (div_done) begin
          y0   <= mapped_y;
          x    <= '0;
          y    <= '0;
          iter <= '0;
          // zero limit: no iteration, pixel counts as inside
          escape_count <= '0;
          inside_set   <= 1'b1;
        end
      end
      S_SQY: xx_q <= prod_sh;
      S_XY: begin
        yy_q         <= prod_sh;
        escape_count <= iter;
        inside_set   <= 1'b0;
      end
      S_UPD: begin
        x            <= x_new;
        y            <= y_new;
        iter         <= iter_inc;
        escape_count <= iter_inc;
        inside_set   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("start transfer did not make the block busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == S_DX_WAIT || state == S_DY_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule
